>>> design/tdat_pkg.sv
// Shared constants, codes and types of the time-of-day alarm table.
// No dependencies; every other design file imports this package.
`default_nettype none

package tdat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ID_W        = 16;
    localparam int MIN_W       = 11;
    localparam int CMD_W       = 2;
    localparam int KIND_W      = 2;

    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REGISTERED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL         = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNREGISTERED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FIRED        = 2'd3;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UNREG,
        ST_TICK
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [MIN_W-1:0] minute;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } wr_t;

    typedef struct packed {
        logic              load;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } push_t;

endpackage

`default_nettype wire

>>> design/tdat_if.sv
// Valid/ready channel interfaces for the alarm table: command in, result out.
// Depends on tdat_pkg for field widths.
`default_nettype none

interface tdat_cmd_if;
    import tdat_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [MIN_W-1:0] alarm_minute;
    logic [ID_W-1:0]  target_id;
    logic [MIN_W-1:0] now_minute;
    logic             clock_ok;

    modport source (
        output valid, command, alarm_minute, target_id, now_minute, clock_ok,
        input  ready
    );
    modport sink (
        input  valid, command, alarm_minute, target_id, now_minute, clock_ok,
        output ready
    );
endinterface

interface tdat_rsp_if;
    import tdat_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   alarm_id;
    logic              last;

    modport source (
        output valid, kind, alarm_id, last,
        input  ready
    );
    modport sink (
        input  valid, kind, alarm_id, last,
        output ready
    );
endinterface

`default_nettype wire

>>> design/tdat_mem.sv
// Alarm entry memory: one write port, one read port, registered read data.
// Depends on tdat_pkg.
`default_nettype none

module tdat_mem (
    input  wire logic               clk,
    input  wire tdat_pkg::wr_t      wr,
    input  wire logic               rd_en,
    input  wire logic [tdat_pkg::ADDR_W-1:0] rd_addr,
    output tdat_pkg::entry_t        rd_data
);
    import tdat_pkg::*;

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/tdat_outreg.sv
// Result output register: holds one result until the sink takes it.
// Depends on tdat_pkg and tdat_if.
`default_nettype none

module tdat_outreg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tdat_pkg::push_t push,
    output logic                free,
    tdat_rsp_if.source          rsp
);
    import tdat_pkg::*;

    logic              valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic              last_reg;

    assign free = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.load)
        begin
            kind_reg <= push.kind;
            id_reg   <= push.id;
            last_reg <= push.last;
        end
    end

    assign rsp.valid    = valid_reg;
    assign rsp.kind     = kind_reg;
    assign rsp.alarm_id = id_reg;
    assign rsp.last     = last_reg;

endmodule

`default_nettype wire

>>> design/tdat_ctrl.sv
// Command sequencer: registers entries, compacts the table on unregister and
// scans it on a tick. Depends on tdat_pkg and tdat_if.
`default_nettype none

module tdat_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    tdat_cmd_if.sink                 cmd,
    input  wire tdat_pkg::entry_t    rd_data,
    input  wire logic                out_free,
    output logic                     rd_en,
    output logic [tdat_pkg::ADDR_W-1:0] rd_addr,
    output tdat_pkg::wr_t            wr,
    output tdat_pkg::push_t          push
);
    import tdat_pkg::*;

    state_t           state_reg,      state_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [CNT_W-1:0] rd_idx_reg,     rd_idx_next;
    logic [CNT_W-1:0] wr_idx_reg,     wr_idx_next;
    logic             dv_reg,         dv_next;
    logic [MIN_W-1:0] lo_reg,         lo_next;
    logic [MIN_W-1:0] hi_reg,         hi_next;
    logic [ID_W-1:0]  tid_reg,        tid_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]  pend_id_reg,    pend_id_next;
    logic [MIN_W-1:0] last_min_reg,   last_min_next;
    logic [ID_W-1:0]  id_ctr_reg,     id_ctr_next;

    logic hit;
    logic more;

    assign hit  = dv_reg && (lo_reg < rd_data.minute) && (rd_data.minute <= hi_reg);
    assign more = rd_idx_reg < count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            dv_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            last_min_reg   <= '0;
            id_ctr_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            dv_reg         <= dv_next;
            pend_valid_reg <= pend_valid_next;
            last_min_reg   <= last_min_next;
            id_ctr_reg     <= id_ctr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        tid_reg     <= tid_next;
        pend_id_reg <= pend_id_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        dv_next         = dv_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        tid_next        = tid_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        last_min_next   = last_min_reg;
        id_ctr_next     = id_ctr_reg;

        cmd.ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = rd_idx_reg[ADDR_W-1:0];
        wr        = '0;
        push      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = out_free;
                if (cmd.valid && out_free)
                begin
                    unique case (cmd.command)
                        CMD_REGISTER:
                        begin
                            push.load = 1'b1;
                            push.last = 1'b1;
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                push.kind = KIND_FULL;
                            end
                            else
                            begin
                                id_ctr_next = (id_ctr_reg == ID_MAX) ? ID_W'(1)
                                                                     : id_ctr_reg + ID_W'(1);
                                wr.en          = 1'b1;
                                wr.addr        = count_reg[ADDR_W-1:0];
                                wr.data.id     = id_ctr_next;
                                wr.data.minute = cmd.alarm_minute;
                                count_next     = count_reg + CNT_W'(1);
                                push.kind      = KIND_REGISTERED;
                                push.id        = id_ctr_next;
                            end
                        end
                        CMD_UNREGISTER:
                        begin
                            push.load   = 1'b1;
                            push.kind   = KIND_UNREGISTERED;
                            push.last   = 1'b1;
                            tid_next    = cmd.target_id;
                            rd_idx_next = '0;
                            wr_idx_next = '0;
                            dv_next     = 1'b0;
                            state_next  = ST_UNREG;
                        end
                        CMD_TICK:
                        begin
                            if (cmd.clock_ok && (cmd.now_minute != last_min_reg))
                            begin
                                lo_next       = last_min_reg;
                                hi_next       = cmd.now_minute;
                                last_min_next = cmd.now_minute;
                                if (count_reg != '0)
                                begin
                                    rd_idx_next     = '0;
                                    dv_next         = 1'b0;
                                    pend_valid_next = 1'b0;
                                    state_next      = ST_TICK;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_UNREG:
            begin
                // keep every entry whose id differs, packed toward the front
                if (dv_reg && (rd_data.id != tid_reg))
                begin
                    wr.en       = 1'b1;
                    wr.addr     = wr_idx_reg[ADDR_W-1:0];
                    wr.data     = rd_data;
                    wr_idx_next = wr_idx_reg + CNT_W'(1);
                end
                if (more)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    dv_next     = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                end
                if (!more && !dv_reg)
                begin
                    count_next = wr_idx_reg;
                    state_next = ST_IDLE;
                end
            end

            ST_TICK:
            begin
                if (!more && !dv_reg)
                begin
                    // scan done: release the held hit as the final result
                    if (pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            push.load       = 1'b1;
                            push.kind       = KIND_FIRED;
                            push.id         = pend_id_reg;
                            push.last       = 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!(hit && pend_valid_reg && !out_free))
                begin
                    // hold one hit back so the final one can carry last
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            push.load = 1'b1;
                            push.kind = KIND_FIRED;
                            push.id   = pend_id_reg;
                            push.last = 1'b0;
                        end
                        pend_id_next    = rd_data.id;
                        pend_valid_next = 1'b1;
                    end
                    if (more)
                    begin
                        rd_en       = 1'b1;
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                        dv_next     = 1'b1;
                    end
                    else
                    begin
                        dv_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/time_of_day_alarm_table_top.sv
// Channel    Dir  Fields                                                    Transfer
// cmd        in   command, alarm_minute, target_id, now_minute, clock_ok    valid & ready
// rsp        out  kind, alarm_id, last                                      valid & ready
//
// Register, unknown commands and ticks that scan nothing complete on acceptance;
// unregister and scanning ticks walk the N stored alarms, one entry memory read
// per cycle, which a tick scan holds while a hit waits on a full result register.
// Every command waits while the result register is full and not taken, and
// tick scans hold there too. Reset empties the table (fill count) and clears
// the id counter and last minute; no clearing pass. Top level of the alarm
// table; depends on tdat_pkg, tdat_if, tdat_mem, tdat_outreg and tdat_ctrl.
`default_nettype none

module time_of_day_alarm_table_top (
    input  wire logic clk,
    input  wire logic rst_n,
    tdat_cmd_if.sink   cmd,
    tdat_rsp_if.source rsp
);
    import tdat_pkg::*;

    entry_t             rd_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    wr_t                wr;
    push_t              push;
    logic               out_free;

    tdat_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tdat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_data  (rd_data),
        .out_free (out_free),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr       (wr),
        .push     (push)
    );

    tdat_outreg u_outreg (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .free  (out_free),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

>>> design/tdat_checker.sv
// Port-level checks of the alarm table, attached to the top level by bind.
// Depends on tdat_pkg.
`default_nettype none

module tdat_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_ready,
    input wire logic [tdat_pkg::CMD_W-1:0] cmd_command,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic [tdat_pkg::KIND_W-1:0] rsp_kind,
    input wire logic [tdat_pkg::ID_W-1:0] rsp_alarm_id,
    input wire logic rsp_last
);
    import tdat_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
            && $stable(rsp_alarm_id) && $stable(rsp_last))
        else $error("result changed while stalled");

    // register and unregister answer in the next cycle
    a_cmd_answer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready
            && (cmd_command == CMD_REGISTER || cmd_command == CMD_UNREGISTER)
        |=> rsp_valid)
        else $error("no answer after register or unregister");

    // a registered or fired id is never zero
    a_new_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_REGISTERED || rsp_kind == KIND_FIRED)
        |-> rsp_alarm_id != '0)
        else $error("zero id reported");

    // single-result answers are final and carry no id unless registered
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_FULL || rsp_kind == KIND_UNREGISTERED)
        |-> rsp_last && rsp_alarm_id == '0)
        else $error("bad full or unregister result");

endmodule

bind time_of_day_alarm_table_top tdat_checker u_tdat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_command  (cmd.command),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_kind     (rsp.kind),
    .rsp_alarm_id (rsp.alarm_id),
    .rsp_last     (rsp.last)
);

`default_nettype wire
